>>> rtl/sparse_set_membership_defines.svh
// Assertion macros shared by the checker of the sparse set block.
// Depends on nothing; SSM_ASSERT expects clk_i and rst_ni in scope, SSM_ASSERT_ALWAYS only clk_i.
`ifndef SPARSE_SET_MEMBERSHIP_DEFINES_SVH
`define SPARSE_SET_MEMBERSHIP_DEFINES_SVH

// Checked at every clock edge while reset is released.
`define SSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, also while reset is held.
`define SSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/ssm_pkg.sv
// Shared types and constants of the sparse set block.
// Depends on nothing; used by the top level, the RAM and the checker.
package ssm_pkg;

  localparam int unsigned ID_W          = 10;
  localparam int unsigned SLOT_W        = 10;
  localparam int unsigned COUNT_W       = 11;
  localparam int unsigned ID_SPACE      = 1 << ID_W;
  localparam int unsigned ENTITIES_DEF  = 1024;
  localparam int unsigned IN_TDATA_W    = 16;
  localparam int unsigned IN_TUSER_W    = 1;
  localparam int unsigned OUT_TDATA_W   = 48;
  localparam int unsigned OUT_PAD_W     = OUT_TDATA_W - (3 * SLOT_W + COUNT_W + 2);

  typedef enum logic [0:0] {
    FUNC_ATTACH = 1'b0,
    FUNC_DETACH = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FETCH,
    ST_RESP
  } state_e;

endpackage

>>> rtl/sparse_set_membership.sv
// Sparse set with swap-remove: attach looks up the slot map, detach then also
// reads the dense list, a read that depends on the slot map's; each is a
// single-port RAM with registered read data. One request is in work at a
// time; a finished result waits in the output register while the next starts.
// After reset the slot map is swept clear, one entry a cycle, over all of its
// min(ENTITIES, 1024) entries (1024 by default) before tready rises.
module sparse_set_membership #(
  parameter int unsigned ENTITIES = ssm_pkg::ENTITIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // entity_id[9:0], zero pad [15:10]
  input  logic [ssm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // func[0]
  input  logic [ssm_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // changed[0], slot[10:1], move_needed[11], move_from[21:12],
  // moved_entity[31:22], member_count[42:32], zero pad [47:43]
  output logic [ssm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned DEPTH = (ENTITIES < ssm_pkg::ID_SPACE) ? ENTITIES
                                                                 : ssm_pkg::ID_SPACE;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MAP_W = ssm_pkg::SLOT_W + 1;

  ssm_pkg::state_e state_q, state_d;

  logic [IDX_W-1:0]               clr_q, clr_d;
  logic                           func_q, func_d;
  logic [ssm_pkg::ID_W-1:0]       id_q, id_d;
  logic [ssm_pkg::COUNT_W-1:0]    count_q, count_d;
  logic [ssm_pkg::SLOT_W-1:0]     freed_q, freed_d;
  logic [ssm_pkg::SLOT_W-1:0]     last_q, last_d;

  logic                           res_changed_q, res_changed_d;
  logic [ssm_pkg::SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic                           res_move_q, res_move_d;
  logic [ssm_pkg::SLOT_W-1:0]     res_from_q, res_from_d;
  logic [ssm_pkg::ID_W-1:0]       res_moved_q, res_moved_d;

  logic                           out_valid_q, out_valid_d;
  logic [ssm_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Slot map: one word per id, presence bit on top of the dense slot.
  logic                 map_en, map_we;
  logic [IDX_W-1:0]     map_addr;
  logic [MAP_W-1:0]     map_wdata, map_rdata;
  // Dense list: one id per slot.
  logic                 dense_en, dense_we;
  logic [IDX_W-1:0]     dense_addr;
  logic [ssm_pkg::ID_W-1:0] dense_wdata, dense_rdata;

  logic                       in_fire;
  logic                       out_free;
  logic                       id_ok;
  logic                       room_ok;
  logic                       map_present;
  logic [ssm_pkg::SLOT_W-1:0] map_slot;
  logic [ssm_pkg::COUNT_W-1:0] count_dec;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign out_free    = !out_valid_q || m_axis_tready;
  assign id_ok       = 32'(id_q) < ENTITIES;
  assign room_ok     = 32'(count_q) < ENTITIES;
  assign map_present = map_rdata[ssm_pkg::SLOT_W];
  assign map_slot    = map_rdata[ssm_pkg::SLOT_W-1:0];
  assign count_dec   = count_q - ssm_pkg::COUNT_W'(1);

  ssm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (MAP_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .en_i    (map_en),
    .we_i    (map_we),
    .addr_i  (map_addr),
    .wdata_i (map_wdata),
    .rdata_o (map_rdata)
  );

  ssm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ssm_pkg::ID_W)
  ) u_dense_ram (
    .clk_i   (clk_i),
    .en_i    (dense_en),
    .we_i    (dense_we),
    .addr_i  (dense_addr),
    .wdata_i (dense_wdata),
    .rdata_o (dense_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssm_pkg::ST_CLEAR: begin
        if (clr_q == IDX_W'(DEPTH - 1)) begin
          state_d = ssm_pkg::ST_IDLE;
        end
      end
      ssm_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = ssm_pkg::ST_LOOKUP;
        end
      end
      ssm_pkg::ST_LOOKUP: begin
        if (func_q == ssm_pkg::FUNC_DETACH && id_ok && map_present &&
            count_q != '0) begin
          state_d = ssm_pkg::ST_FETCH;
        end else begin
          state_d = ssm_pkg::ST_RESP;
        end
      end
      ssm_pkg::ST_FETCH: begin
        state_d = ssm_pkg::ST_RESP;
      end
      ssm_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = ssm_pkg::ST_IDLE;
        end
      end
      default: state_d = ssm_pkg::ST_IDLE;
    endcase
  end

  // Memory accesses and datapath.
  always_comb begin
    s_axis_tready = 1'b0;
    clr_d         = clr_q;
    func_d        = func_q;
    id_d          = id_q;
    count_d       = count_q;
    freed_d       = freed_q;
    last_d        = last_q;
    res_changed_d = res_changed_q;
    res_slot_d    = res_slot_q;
    res_move_d    = res_move_q;
    res_from_d    = res_from_q;
    res_moved_d   = res_moved_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_data_d    = out_data_q;

    map_en      = 1'b0;
    map_we      = 1'b0;
    map_addr    = id_q[IDX_W-1:0];
    map_wdata   = '0;
    dense_en    = 1'b0;
    dense_we    = 1'b0;
    dense_addr  = count_q[IDX_W-1:0];
    dense_wdata = id_q;

    unique case (state_q)
      ssm_pkg::ST_CLEAR: begin
        map_en   = 1'b1;
        map_we   = 1'b1;
        map_addr = clr_q;
        clr_d    = clr_q + IDX_W'(1);
      end
      ssm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          func_d   = s_axis_tuser[0];
          id_d     = s_axis_tdata[ssm_pkg::ID_W-1:0];
          map_en   = 1'b1;
          map_addr = s_axis_tdata[IDX_W-1:0];
        end
      end
      ssm_pkg::ST_LOOKUP: begin
        res_changed_d = 1'b0;
        res_slot_d    = '0;
        res_move_d    = 1'b0;
        res_from_d    = '0;
        res_moved_d   = '0;
        if (func_q == ssm_pkg::FUNC_ATTACH) begin
          if (id_ok && !map_present && room_ok) begin
            map_en        = 1'b1;
            map_we        = 1'b1;
            map_wdata     = {1'b1, count_q[ssm_pkg::SLOT_W-1:0]};
            dense_en      = 1'b1;
            dense_we      = 1'b1;
            count_d       = count_q + ssm_pkg::COUNT_W'(1);
            res_changed_d = 1'b1;
            res_slot_d    = count_q[ssm_pkg::SLOT_W-1:0];
          end
        end else if (id_ok && map_present && count_q != '0) begin
          // Drop the presence bit now and fetch the last member's id.
          map_en     = 1'b1;
          map_we     = 1'b1;
          map_wdata  = {1'b0, map_slot};
          dense_en   = 1'b1;
          dense_addr = count_dec[IDX_W-1:0];
          freed_d    = map_slot;
          last_d     = count_dec[ssm_pkg::SLOT_W-1:0];
          count_d    = count_dec;
        end
      end
      ssm_pkg::ST_FETCH: begin
        res_changed_d = 1'b1;
        res_slot_d    = freed_q;
        // When the freed slot is the last one, the moved member is the
        // removed id itself, so both maps stay as they are.
        if (freed_q != last_q) begin
          dense_en    = 1'b1;
          dense_we    = 1'b1;
          dense_addr  = freed_q[IDX_W-1:0];
          dense_wdata = dense_rdata;
          map_en      = 1'b1;
          map_we      = 1'b1;
          map_addr    = dense_rdata[IDX_W-1:0];
          map_wdata   = {1'b1, freed_q};
          res_move_d  = 1'b1;
          res_from_d  = last_q;
          res_moved_d = dense_rdata;
        end
      end
      ssm_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {{ssm_pkg::OUT_PAD_W{1'b0}}, count_q, res_moved_q, res_from_q,
                         res_move_q, res_slot_q, res_changed_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssm_pkg::ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q        <= func_d;
    id_q          <= id_d;
    freed_q       <= freed_d;
    last_q        <= last_d;
    res_changed_q <= res_changed_d;
    res_slot_q    <= res_slot_d;
    res_move_q    <= res_move_d;
    res_from_q    <= res_from_d;
    res_moved_q   <= res_moved_d;
    out_data_q    <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/ssm_ram.sv
// Single-port synchronous RAM with registered read data, one access a cycle.
// Depends on ssm_pkg for its defaults; instantiated twice by the sparse set top level.
module ssm_ram #(
  parameter int unsigned DEPTH = ssm_pkg::ENTITIES_DEF,
  parameter int unsigned WIDTH = ssm_pkg::SLOT_W,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ssm_checker.sv
// Port-level checker for the sparse set block, bound to its top level.
// Depends on ssm_pkg and the assertion macros in sparse_set_membership_defines.svh.
`include "sparse_set_membership_defines.svh"

module ssm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ssm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                        o_changed;
  logic [ssm_pkg::SLOT_W-1:0]  o_slot;
  logic                        o_move;
  logic [ssm_pkg::SLOT_W-1:0]  o_from;
  logic [ssm_pkg::COUNT_W-1:0] o_count;

  assign o_changed = m_axis_tdata[0];
  assign o_slot    = m_axis_tdata[10:1];
  assign o_move    = m_axis_tdata[11];
  assign o_from    = m_axis_tdata[21:12];
  assign o_count   = m_axis_tdata[42:32];

  // A stalled result keeps its value.
  `SSM_ASSERT(a_out_hold,
              m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
              "result changed while stalled")

  // Only one request is in work, so ready drops right after each accepted one.
  `SSM_ASSERT(a_one_in_work,
              s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
              "request accepted while another is in work")

  // A request that changed nothing reports no slot and no move.
  `SSM_ASSERT(a_nochange_quiet,
              m_axis_tvalid && !o_changed |-> !o_move && o_slot == '0,
              "unchanged request reports a slot or a move")

  // The moved member always comes from the old last slot, which is the new count.
  `SSM_ASSERT(a_move_from_last,
              m_axis_tvalid && o_move |-> o_changed &&
                o_from == o_count[ssm_pkg::SLOT_W-1:0] && o_from != o_slot,
              "move source is not the last slot")

  // Reset holds the output empty.
  `SSM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "result valid out of reset")

endmodule

bind sparse_set_membership ssm_checker u_ssm_checker (.*);

>>> verif/sparse_set_membership_test.sv
// Self-checking testbench for the sparse set block: a stimulus table and random
// attach/detach traffic, checked against an in-bench sparse set predictor.
// Depends on ssm_pkg and sparse_set_membership.
`timescale 1ns / 100ps

module sparse_set_membership_test;
  import ssm_pkg::*;

  localparam int unsigned DIRECTED_ROWS = 23;
  localparam int unsigned RANDOM_ITEMS  = 1825;
  localparam int unsigned MIXED_ITEMS   = 600;
  localparam int unsigned DRAIN_CYCLES  = 32;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_GAP       = 12;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [COUNT_W-1:0]   member_count;
    logic [ID_W-1:0]      moved_entity;
    logic [SLOT_W-1:0]    move_from;
    logic                 move_needed;
    logic [SLOT_W-1:0]    slot;
    logic                 changed;
  } membership_result_t;

  typedef struct {
    func_e              func;
    logic [ID_W-1:0]    id;
    bit                 by_hand;
    membership_result_t want;
  } directed_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [IN_TUSER_W-1:0]  s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor state: presence flags, dense member list, id to slot map, count.
  logic               member_flag [ID_SPACE];
  logic [ID_W-1:0]    roster      [ID_SPACE];
  logic [SLOT_W-1:0]  slot_map    [ID_SPACE];
  logic [COUNT_W-1:0] member_total;

  membership_result_t expected_results[$];
  directed_row_t      directed_rows [DIRECTED_ROWS];
  int unsigned        mismatch_count;
  int unsigned        cycle_count;
  int                 send_steady;
  int                 take_steady;

  sparse_set_membership u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic membership_result_t typed_result(logic chg, int unsigned slot,
                                                      logic mv, int unsigned from,
                                                      int unsigned moved, int unsigned cnt);
    membership_result_t r;
    r = '0;
    r.changed      = chg;
    r.slot         = slot[SLOT_W-1:0];
    r.move_needed  = mv;
    r.move_from    = from[SLOT_W-1:0];
    r.moved_entity = moved[ID_W-1:0];
    r.member_count = cnt[COUNT_W-1:0];
    return r;
  endfunction

  function automatic string describe(membership_result_t r);
    return $sformatf("chg=%0d slot=%0d move=%0d from=%0d moved=%0d count=%0d pad=%0h",
                     r.changed, r.slot, r.move_needed, r.move_from, r.moved_entity,
                     r.member_count, r.pad);
  endfunction

  // Applies one request to the predictor state and returns its result.
  function automatic membership_result_t apply_membership(func_e f, logic [ID_W-1:0] id);
    membership_result_t r;
    logic [SLOT_W-1:0]  freed;
    logic [SLOT_W-1:0]  last_slot;
    logic [ID_W-1:0]    last_id;
    r = '0;
    if (f == FUNC_ATTACH) begin
      if (!member_flag[id] && member_total < ID_SPACE) begin
        member_flag[id] = 1'b1;
        roster[member_total[SLOT_W-1:0]] = id;
        slot_map[id] = member_total[SLOT_W-1:0];
        r.slot = member_total[SLOT_W-1:0];
        member_total = member_total + 1'b1;
        r.changed = 1'b1;
      end
    end else if (member_flag[id] && member_total > 0) begin
      member_flag[id] = 1'b0;
      freed = slot_map[id];
      member_total = member_total - 1'b1;
      last_slot = member_total[SLOT_W-1:0];
      last_id = roster[last_slot];
      // The last member fills the hole; a no-op when the freed slot was last.
      roster[freed] = last_id;
      slot_map[last_id] = freed;
      r.slot = freed;
      r.changed = 1'b1;
      if (freed != last_slot) begin
        r.move_needed  = 1'b1;
        r.move_from    = last_slot;
        r.moved_entity = last_id;
      end
    end
    r.member_count = member_total;
    return r;
  endfunction

  // Idle cycles before the next request or taken result; now and then a run with none.
  function automatic int draw_gap(inout int steady_left);
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      steady_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic issue_request(func_e f, logic [ID_W-1:0] id, bit by_hand,
                               membership_result_t hand_want);
    int                 gap;
    membership_result_t predicted;
    gap = draw_gap(send_steady);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - ID_W){1'b0}}, id};
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_membership(f, id);
    expected_results.push_back(by_hand ? hand_want : predicted);
  endtask

  initial begin : result_monitor
    membership_result_t got;
    membership_result_t want;
    int                 gap;
    m_axis_tready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      gap = draw_gap(take_steady);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: %s", describe(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch: expected %s", describe(want));
            $display("          actual   %s", describe(got));
          end
        end
      end
    end
  end

  initial begin : stimulus
    func_e           f;
    logic [ID_W-1:0] id;
    bit              growing;
    bit              want_attach;
    int unsigned     band_floor;
    int unsigned     band_top;
    int unsigned     noise_pct;
    int unsigned     favor_pct;
    int unsigned     attach_pct;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_ATTACH;
    cycle_count   = 0;
    mismatch_count = 0;
    send_steady   = 0;
    take_steady   = 0;
    for (int i = 0; i < ID_SPACE; i++) member_flag[i] = 1'b0;
    member_total = '0;

    // Rows with a hand-written result walk the empty set, both id extremes,
    // a swap on detach, both no-change answers and removal of the last slot.
    directed_rows = '{
      '{FUNC_DETACH, 10'd0,    1'b1, typed_result(0, 0, 0, 0, 0, 0)},
      '{FUNC_ATTACH, 10'd0,    1'b1, typed_result(1, 0, 0, 0, 0, 1)},
      '{FUNC_ATTACH, 10'd1023, 1'b1, typed_result(1, 1, 0, 0, 0, 2)},
      '{FUNC_ATTACH, 10'd0,    1'b1, typed_result(0, 0, 0, 0, 0, 2)},
      '{FUNC_DETACH, 10'd0,    1'b1, typed_result(1, 0, 1, 1, 1023, 1)},
      '{FUNC_DETACH, 10'd0,    1'b1, typed_result(0, 0, 0, 0, 0, 1)},
      '{FUNC_DETACH, 10'd1023, 1'b1, typed_result(1, 0, 0, 0, 0, 0)},
      '{FUNC_ATTACH, 10'd1023, 1'b1, typed_result(1, 0, 0, 0, 0, 1)},
      '{FUNC_ATTACH, 10'd1,    1'b0, '0},
      '{FUNC_ATTACH, 10'd2,    1'b0, '0},
      '{FUNC_ATTACH, 10'd512,  1'b0, '0},
      '{FUNC_ATTACH, 10'd341,  1'b0, '0},
      '{FUNC_ATTACH, 10'd682,  1'b0, '0},
      '{FUNC_DETACH, 10'd512,  1'b0, '0},
      '{FUNC_DETACH, 10'd682,  1'b0, '0},
      '{FUNC_ATTACH, 10'd512,  1'b0, '0},
      '{FUNC_DETACH, 10'd1023, 1'b0, '0},
      '{FUNC_ATTACH, 10'd1023, 1'b0, '0},
      '{FUNC_ATTACH, 10'd0,    1'b0, '0},
      '{FUNC_DETACH, 10'd1,    1'b0, '0},
      '{FUNC_DETACH, 10'd2,    1'b0, '0},
      '{FUNC_ATTACH, 10'd0,    1'b0, '0},
      '{FUNC_DETACH, 10'd7,    1'b0, '0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++)
      issue_request(directed_rows[r].func, directed_rows[r].id,
                    directed_rows[r].by_hand, directed_rows[r].want);

    // First the set swings inside a small band, then it is filled to capacity
    // and shrunk again for the rest of the run.
    growing    = 1'b1;
    band_floor = $urandom_range(0, 4);
    band_top   = $urandom_range(8, 64);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < MIXED_ITEMS) begin
        if (growing && member_total >= band_top) begin
          growing = 1'b0;
        end else if (!growing && member_total <= band_floor) begin
          growing    = 1'b1;
          band_floor = $urandom_range(0, 4);
          band_top   = $urandom_range(8, 64);
        end
        noise_pct = 10;
        favor_pct = 85;
      end else begin
        if (n == MIXED_ITEMS) growing = 1'b1;
        if (member_total == ID_SPACE) growing = 1'b0;
        noise_pct = 3;
        favor_pct = 98;
      end

      if ($urandom_range(0, 99) < noise_pct) begin
        f  = func_e'($urandom_range(0, 1));
        id = $urandom_range(0, ID_SPACE - 1);
      end else begin
        attach_pct  = growing ? favor_pct : 100 - favor_pct;
        want_attach = $urandom_range(0, 99) < attach_pct;
        if (want_attach && member_total < ID_SPACE) begin
          f = FUNC_ATTACH;
          do id = $urandom_range(0, ID_SPACE - 1); while (member_flag[id]);
        end else if (!want_attach && member_total > 0) begin
          f  = FUNC_DETACH;
          id = roster[$urandom_range(0, member_total - 1)];
        end else begin
          f  = want_attach ? FUNC_ATTACH : FUNC_DETACH;
          id = $urandom_range(0, ID_SPACE - 1);
        end
      end
      issue_request(f, id, 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
